// ===== src/chb_pkg.sv =====
// Shared types and command codes for the canonical Huffman encoder.
package chb_pkg;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_BUILD  = 2'd1;
   localparam logic [1:0] CMD_ENCODE = 2'd2;

   localparam int BYTE_BITS = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENC_RD,
      ST_EMIT,
      ST_BUILD
   } ctl_state_type;

   typedef enum logic [1:0] {
      BLD_IDLE,
      BLD_COUNT,
      BLD_NEXT,
      BLD_ASSIGN
   } bld_phase_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic code_wr_en;
   } bld_ctl_type;

   typedef struct packed {
      logic restart;
      logic append;
      logic pop;
   } pack_ctl_type;

endpackage

// ===== src/chb_req_if.sv =====
// Request and response channel interfaces of the canonical Huffman encoder.
interface chb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] symbol;
   logic [4:0] code_length;

   modport source (output valid, command, symbol, code_length, input ready);
   modport sink   (input valid, command, symbol, code_length, output ready);
endinterface

interface chb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

// ===== src/canonical_huffman_encoder.sv =====
// Top level of the canonical Huffman byte encoder.
//
// Usage:
//   req_ch carries one item per handshake: command 0 loads the code length
//   of a symbol, command 1 builds canonical codes, command 2 encodes a symbol.
//   rsp_ch returns packed bytes, earliest bit in the MSB; last marks the
//   final byte caused by an encode item. csr_wr_en/csr_wr_data set the
//   number of leading zero pad bits and restart the packer.
// Timing:
//   A load is written in the cycle it is taken. An encode reads the
//   length and code memories, appends the code in ST_ENC_RD, then offers up to
//   floor((MAX_CODE_BITS + 7) / 8) bytes, one per cycle while rsp_ch is
//   ready; req_ch is ready again the cycle after the last byte is taken,
//   or once ST_ENC_RD and ST_EMIT have passed if the item completes no byte.
//   A build sweeps the length memory twice, one symbol a cycle, deriving
//   the first code of each code length in turn between the sweeps.
// Reset clears all lengths, the pad count and the packer. While rsp_ch is
//   stalled the current byte holds and no new item is taken.
module canonical_huffman_encoder #(
   parameter int MAX_CODE_BITS = 16,
   parameter int SYMBOL_COUNT  = 256
) (
   input  logic       clock,
   input  logic       reset,
   chb_req_if.sink    req_ch,
   chb_rsp_if.source  rsp_ch,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);
   import chb_pkg::*;

   localparam int AW = $clog2(SYMBOL_COUNT);

   ctl_state_type            state_ff, state_in;
   logic [2:0]               lead_pad_ff;
   logic [SYMBOL_COUNT-1:0]  len_valid_ff;
   logic                     len_vld_rd_ff;

   logic                     load_ok, sym_ok, len_we, bld_start;
   logic [AW-1:0]            req_addr, len_raddr, bld_len_addr;
   logic [4:0]               len_rdata, len_masked;
   logic [MAX_CODE_BITS-1:0] code_rdata, code_wdata;
   logic [AW-1:0]            code_waddr;
   bld_ctl_type              bld_ctl;
   pack_ctl_type             pk_ctl;
   logic                     pk_has_byte;
   logic [2:0]               pk_pad;

   assign req_addr   = req_ch.symbol[AW-1:0];
   assign sym_ok     = (int'(req_ch.symbol) < SYMBOL_COUNT);
   assign load_ok    = sym_ok && (int'(req_ch.code_length) <= MAX_CODE_BITS);
   assign len_raddr  = bld_ctl.busy ? bld_len_addr : req_addr;
   assign len_masked = len_vld_rd_ff ? len_rdata : 5'd0;
   assign pk_pad     = csr_wr_en ? csr_wr_data : lead_pad_ff;

   chb_ram #(.WIDTH(5), .DEPTH(SYMBOL_COUNT)) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (req_addr),
      .wr_data (req_ch.code_length),
      .rd_addr (len_raddr),
      .rd_data (len_rdata)
   );

   chb_ram #(.WIDTH(MAX_CODE_BITS), .DEPTH(SYMBOL_COUNT)) u_code_ram (
      .clock   (clock),
      .wr_en   (bld_ctl.code_wr_en),
      .wr_addr (code_waddr),
      .wr_data (code_wdata),
      .rd_addr (req_addr),
      .rd_data (code_rdata)
   );

   chb_build #(.MAX_CODE_BITS(MAX_CODE_BITS), .SYMBOL_COUNT(SYMBOL_COUNT)) u_build (
      .clock      (clock),
      .reset      (reset),
      .start      (bld_start),
      .len_rdata  (len_masked),
      .len_raddr  (bld_len_addr),
      .code_waddr (code_waddr),
      .code_wdata (code_wdata),
      .ctl        (bld_ctl)
   );

   chb_pack #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_pack (
      .clock    (clock),
      .reset    (reset),
      .ctl      (pk_ctl),
      .pad      (pk_pad),
      .len      (len_masked),
      .code     (code_rdata),
      .out_byte (rsp_ch.out_byte),
      .last     (rsp_ch.last),
      .has_byte (pk_has_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lead_pad_ff  <= 3'd0;
         len_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            lead_pad_ff <= csr_wr_data;
         end
         if (len_we) begin
            len_valid_ff[req_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_vld_rd_ff <= len_valid_ff[len_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      req_ch.ready  = 1'b0;
      rsp_ch.valid  = 1'b0;
      len_we        = 1'b0;
      bld_start     = 1'b0;
      pk_ctl        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               case (req_ch.command)
                  CMD_LOAD:   len_we = load_ok;
                  CMD_BUILD: begin
                     bld_start = 1'b1;
                     state_in  = ST_BUILD;
                  end
                  CMD_ENCODE: begin
                     if (sym_ok) begin
                        state_in = ST_ENC_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ENC_RD: begin
            pk_ctl.append = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_ch.valid = pk_has_byte;
            if (!pk_has_byte) begin
               state_in = ST_IDLE;
            end else if (rsp_ch.ready) begin
               pk_ctl.pop = 1'b1;
               if (rsp_ch.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BUILD: begin
            if (bld_ctl.done) begin
               pk_ctl.restart = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_wr_en) begin
         pk_ctl.restart = 1'b1;
      end
   end

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last) |=> (state_ff == ST_IDLE))
      else $error("last byte taken but encoder did not return to idle");

   a_ready_not_building: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !bld_ctl.busy)
      else $error("request taken while build sequencer is busy");

   a_code_write_in_build: assert property (@(posedge clock) disable iff (reset)
      bld_ctl.code_wr_en |-> (state_ff == ST_BUILD))
      else $error("code memory written outside a build");

   a_done_in_build: assert property (@(posedge clock) disable iff (reset)
      bld_ctl.done |-> (state_ff == ST_BUILD) && !$past(bld_start))
      else $error("build done outside a build or right after start");

endmodule

// ===== src/chb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== src/chb_build.sv =====
// Canonical code build sequencer: count lengths, derive first codes, assign codes.
module chb_build #(
   parameter int MAX_CODE_BITS = 16,
   parameter int SYMBOL_COUNT  = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [4:0]                      len_rdata,
   output logic [$clog2(SYMBOL_COUNT)-1:0] len_raddr,
   output logic [$clog2(SYMBOL_COUNT)-1:0] code_waddr,
   output logic [MAX_CODE_BITS-1:0]        code_wdata,
   output chb_pkg::bld_ctl_type            ctl
);
   import chb_pkg::*;

   localparam int AW  = $clog2(SYMBOL_COUNT);
   localparam int SCW = AW + 1;
   localparam int LIW = $clog2(MAX_CODE_BITS + 1);
   localparam int CW  = $clog2(SYMBOL_COUNT + 1);
   localparam int SW  = ((MAX_CODE_BITS > CW) ? MAX_CODE_BITS : CW) + 1;

   bld_phase_type           phase_ff, phase_in;
   logic [SCW-1:0]          sym_ff;
   logic                    pipe_ff;
   logic [AW-1:0]           pipe_addr_ff;
   logic [LIW-1:0]          bit_ff;
   logic [MAX_CODE_BITS-1:0] code_ff;
   logic [CW-1:0]           counts_ff    [MAX_CODE_BITS+1];
   logic [MAX_CODE_BITS-1:0] next_code_ff [MAX_CODE_BITS+1];

   logic                    issue;
   logic                    len_nz;
   logic [LIW-1:0]          len_idx;
   logic [SW-1:0]           sum;
   logic [SW:0]             sum_shl;
   logic [MAX_CODE_BITS-1:0] first_code;

   assign issue     = ((phase_ff == BLD_COUNT) || (phase_ff == BLD_ASSIGN))
                      && (sym_ff < SCW'(SYMBOL_COUNT));
   assign len_nz    = (len_rdata != 5'd0);
   assign len_idx   = LIW'(len_rdata);
   assign len_raddr = sym_ff[AW-1:0];
   assign sum       = SW'(code_ff) + SW'(counts_ff[bit_ff - LIW'(1)]);
   assign sum_shl   = {sum, 1'b0};
   assign first_code = sum_shl[MAX_CODE_BITS-1:0];

   assign code_waddr = pipe_addr_ff;
   assign code_wdata = len_nz ? next_code_ff[len_idx] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= BLD_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      ctl.busy       = (phase_ff != BLD_IDLE);
      ctl.done       = 1'b0;
      ctl.code_wr_en = 1'b0;
      unique case (phase_ff)
         BLD_IDLE: begin
            if (start) begin
               phase_in = BLD_COUNT;
            end
         end
         BLD_COUNT: begin
            if (!issue && !pipe_ff) begin
               phase_in = BLD_NEXT;
            end
         end
         BLD_NEXT: begin
            if (bit_ff == LIW'(MAX_CODE_BITS)) begin
               phase_in = BLD_ASSIGN;
            end
         end
         BLD_ASSIGN: begin
            ctl.code_wr_en = pipe_ff;
            if (!issue && !pipe_ff) begin
               ctl.done = 1'b1;
               phase_in = BLD_IDLE;
            end
         end
         default: phase_in = BLD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff <= 1'b0;
      end else begin
         pipe_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      pipe_addr_ff <= sym_ff[AW-1:0];
      if (issue) begin
         sym_ff <= sym_ff + SCW'(1);
      end
      case (phase_ff)
         BLD_IDLE: begin
            sym_ff <= '0;
            bit_ff <= LIW'(1);
            code_ff <= '0;
            for (int i = 0; i <= MAX_CODE_BITS; i++) begin
               counts_ff[i] <= '0;
            end
         end
         BLD_COUNT: begin
            if (pipe_ff && len_nz) begin
               counts_ff[len_idx] <= counts_ff[len_idx] + CW'(1);
            end
            if (!issue && !pipe_ff) begin
               sym_ff <= '0;
            end
         end
         BLD_NEXT: begin
            next_code_ff[bit_ff] <= first_code;
            code_ff              <= first_code;
            bit_ff               <= bit_ff + LIW'(1);
         end
         BLD_ASSIGN: begin
            if (pipe_ff && len_nz) begin
               next_code_ff[len_idx] <= next_code_ff[len_idx] + MAX_CODE_BITS'(1);
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== src/chb_pack.sv =====
// Bit packer: appends codes MSB first and hands out completed bytes.
module chb_pack #(
   parameter int MAX_CODE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  chb_pkg::pack_ctl_type     ctl,
   input  logic [2:0]                pad,
   input  logic [4:0]                len,
   input  logic [MAX_CODE_BITS-1:0]  code,
   output logic [7:0]                out_byte,
   output logic                      last,
   output logic                      has_byte
);
   import chb_pkg::*;

   localparam int PW  = MAX_CODE_BITS + 7;
   localparam int CNW = $clog2(MAX_CODE_BITS + 8);

   logic [PW-1:0]  pend_ff, pend_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]  kept;
   logic [MAX_CODE_BITS-1:0] code_bits;

   assign kept      = pend_ff & ~({PW{1'b1}} << cnt_ff);
   assign code_bits = code & ~({MAX_CODE_BITS{1'b1}} << len);
   assign has_byte  = (int'(cnt_ff) >= BYTE_BITS);
   assign last      = (int'(cnt_ff) < 2 * BYTE_BITS);
   assign out_byte  = 8'(pend_ff >> (cnt_ff - CNW'(BYTE_BITS)));

   always_comb begin
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      if (ctl.restart) begin
         pend_in = '0;
         cnt_in  = CNW'(pad);
      end else if (ctl.append) begin
         pend_in = (kept << len) | {7'd0, code_bits};
         cnt_in  = cnt_ff + CNW'(len);
      end else if (ctl.pop) begin
         cnt_in  = cnt_ff - CNW'(BYTE_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
